### hw/rtl/elom_pkg.sv
// Package with the shared widths, codes and types of the extent list offset mapper.
package elom_pkg;

  localparam int MAX_EXTENTS  = 32;
  localparam int IDX_W        = 5;
  localparam int COUNT_W      = 6;
  localparam int SECTOR_SHIFT = 11;
  localparam int LBA_W        = 32;
  localparam int SIZE_W       = 32;
  localparam int POS_W        = 48;
  localparam int DISK_W       = 44;
  localparam int START_W      = 38;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_MAP  = 1'b1;

  localparam logic ST_OK       = 1'b0;
  localparam logic ST_PAST_EOF = 1'b1;

  typedef struct packed {
    logic              opcode;
    logic [IDX_W-1:0]  extent_index;
    logic [LBA_W-1:0]  extent_lba;
    logic [SIZE_W-1:0] ext_bytes;
    logic [POS_W-1:0]  file_offset;
    logic [POS_W-1:0]  byte_count;
  } req_t;

  typedef struct packed {
    logic [DISK_W-1:0] disk_addr;
    logic [SIZE_W-1:0] segment_length;
    logic              status;
    logic              last;
  } rsp_t;

endpackage

### hw/rtl/elom_ifs.sv
// Handshake interfaces for the request, result and configuration channels.
interface elom_req_if;
  logic           valid;
  logic           ready;
  elom_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface elom_rsp_if;
  logic           valid;
  logic           ready;
  elom_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface elom_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [elom_pkg::COUNT_W-1:0]       data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/extent_list_offset_mapper_unit.sv
// Top level of the extent list offset mapper: extent table, walk sequencer and result register.
//
// The req channel carries load and map items. A load item writes one extent
// entry (start sector, byte length). A map item walks the first ext_count
// entries, at most 32, in order and sends one result item on the rsp
// channel for each extent it overlaps, then a beyond-end-of-file result if
// bytes remain. A zero-count map gives one empty result with last set.
// The walk passes the check and hit states for an extent that the request
// misses and the check, hit and segment states for one that it overlaps,
// reading the table through its single read port.
// The req channel is not ready while a map item is being walked.
// The cfg channel writes the extent count register and is always ready; write
// it only while the block is idle.
// A result waits in an output register; while the receiver stalls, the walk
// holds at the next result and loses nothing.
// Reset clears the extent count and the sequencer; the table is undefined until
// each entry is loaded.
module extent_list_offset_mapper_unit (
  input logic         clk,
  input logic         rst,
  elom_req_if.sink    req,
  elom_rsp_if.source  rsp,
  elom_cfg_if.sink    cfg
);
  import elom_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CHECK = 5'b00010,
    S_HIT   = 5'b00100,
    S_SEG   = 5'b01000,
    S_FINAL = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [LBA_W+SIZE_W-1:0] ext_mem [MAX_EXTENTS];
  logic [LBA_W-1:0]        rd_lba;
  logic [SIZE_W-1:0]       rd_len;

  logic [COUNT_W-1:0] ext_count;
  logic [COUNT_W-1:0] used;
  logic [COUNT_W-1:0] idx, idx_next;
  logic [POS_W-1:0]   loc, loc_next;
  logic [POS_W-1:0]   count, count_next;
  logic [START_W-1:0] start, start_next;
  logic [START_W-1:0] end_r, end_next;
  logic [SIZE_W-1:0]  off_r, off_next;

  logic               req_fire;
  logic               slot_free;
  logic               emit;
  rsp_t               emit_data;

  logic [START_W-1:0] sum_end;
  logic               hit;
  logic [POS_W-1:0]   off_full;
  logic [SIZE_W-1:0]  avail;
  logic [SIZE_W-1:0]  take;
  logic [DISK_W-1:0]  disk;
  logic [POS_W-1:0]   count_left;

  assign req.ready = (state == S_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign cfg.ready = 1'b1;
  assign slot_free = !rsp.valid || rsp.ready;

  assign used = (ext_count > COUNT_W'(MAX_EXTENTS)) ? COUNT_W'(MAX_EXTENTS) : ext_count;

  assign sum_end  = start + START_W'(rd_len);
  assign hit      = POS_W'(sum_end) > loc;
  assign off_full = loc - POS_W'(start);

  assign avail      = rd_len - off_r;
  assign take       = (count < POS_W'(avail)) ? count[SIZE_W-1:0] : avail;
  assign disk       = DISK_W'({rd_lba, SECTOR_SHIFT'(0)}) + DISK_W'(off_r);
  assign count_left = count - POS_W'(take);

  always_comb begin
    state_next = state;
    idx_next   = idx;
    loc_next   = loc;
    count_next = count;
    start_next = start;
    end_next   = end_r;
    off_next   = off_r;
    emit       = 1'b0;
    emit_data  = '0;
    case (state)
      S_IDLE: begin
        idx_next = '0;
        if (req_fire && req.data.opcode == OP_MAP) begin
          loc_next   = req.data.file_offset;
          count_next = req.data.byte_count;
          start_next = '0;
          state_next = (req.data.byte_count == '0) ? S_FINAL : S_CHECK;
        end
      end
      S_CHECK: begin
        if (count == '0) begin
          state_next = S_IDLE;
        end else if (idx >= used) begin
          state_next = S_FINAL;
        end else begin
          state_next = S_HIT;
        end
      end
      S_HIT: begin
        end_next = sum_end;
        off_next = (loc > POS_W'(start)) ? off_full[SIZE_W-1:0] : '0;
        if (hit) begin
          state_next = S_SEG;
        end else begin
          start_next = sum_end;
          idx_next   = idx + COUNT_W'(1);
          state_next = S_CHECK;
        end
      end
      S_SEG: begin
        if (slot_free) begin
          emit                     = 1'b1;
          emit_data.disk_addr      = disk;
          emit_data.segment_length = take;
          emit_data.status         = ST_OK;
          emit_data.last           = (count_left == '0);
          count_next               = count_left;
          loc_next                 = loc + POS_W'(take);
          start_next               = end_r;
          idx_next                 = idx + COUNT_W'(1);
          state_next               = S_CHECK;
        end
      end
      S_FINAL: begin
        if (slot_free) begin
          emit             = 1'b1;
          emit_data.status = (count != '0) ? ST_PAST_EOF : ST_OK;
          emit_data.last   = 1'b1;
          state_next       = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (req_fire && req.data.opcode == OP_LOAD) begin
      ext_mem[req.data.extent_index] <= {req.data.extent_lba, req.data.ext_bytes};
    end
    {rd_lba, rd_len} <= ext_mem[idx_next[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ext_count <= '0;
      rsp.valid <= 1'b0;
      idx       <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      if (cfg.valid && cfg.ready) begin
        ext_count <= cfg.data;
      end
      if (emit) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    loc   <= loc_next;
    count <= count_next;
    start <= start_next;
    end_r <= end_next;
    off_r <= off_next;
    if (emit) begin
      rsp.data <= emit_data;
    end
  end

endmodule

### sim/extent_list_offset_mapper_unit_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the extent list offset mapper with a built-in segment predictor.
module extent_list_offset_mapper_unit_test;
  import elom_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES = 110;
  localparam int RANDOM_PER_PHASE = 33;
  localparam int NUM_PHASES = 12;
  localparam logic [COUNT_W-1:0] PHASE_COUNTS [NUM_PHASES] = '{
    6'd4, 6'd0, 6'd1, 6'd32, 6'd63, 6'd33, 6'd7, 6'd2, 6'd20, 6'd32, 6'd12, 6'd5
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  elom_req_if req_ch ();
  elom_rsp_if rsp_ch ();
  elom_cfg_if cfg_ch ();

  extent_list_offset_mapper_unit u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  req_t               pending_items [$];
  rsp_t               segment_q [$];
  logic [LBA_W-1:0]   sector_tab [MAX_EXTENTS];
  logic [SIZE_W-1:0]  length_tab [MAX_EXTENTS];
  logic [COUNT_W-1:0] ext_count_cfg = '0;
  logic [SIZE_W-1:0]  plan_len [MAX_EXTENTS];
  bit                 plan_written [MAX_EXTENTS];
  int                 plan_used = 0;
  bit                 idle_on = 1'b1;
  int                 errors = 0;
  int                 quiet_cycles = 0;
  int                 req_gap = 0;
  int                 rsp_stall = 0;

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [POS_W-1:0] rand_pos();
    logic [63:0] r;
    r = rand64();
    return r[POS_W-1:0];
  endfunction

  function automatic logic [SIZE_W-1:0] rand_len();
    case ($urandom_range(0, 9))
      0: return '0;
      1, 2: return $urandom;
      3: return $urandom_range(1, 1 << 20);
      default: return $urandom_range(1, 4096);
    endcase
  endfunction

  function automatic void queue_load(input logic [IDX_W-1:0] idx, input logic [LBA_W-1:0] lba,
                                     input logic [SIZE_W-1:0] len);
    req_t item;
    item.opcode = OP_LOAD;
    item.extent_index = idx;
    item.extent_lba = lba;
    item.ext_bytes = len;
    item.file_offset = rand_pos();
    item.byte_count = rand_pos();
    pending_items.push_back(item);
    plan_len[idx] = len;
    plan_written[idx] = 1'b1;
  endfunction

  function automatic void queue_map(input logic [POS_W-1:0] offset, input logic [POS_W-1:0] count);
    req_t item;
    item.opcode = OP_MAP;
    item.extent_index = IDX_W'($urandom);
    item.extent_lba = $urandom;
    item.ext_bytes = $urandom;
    item.file_offset = offset;
    item.byte_count = count;
    pending_items.push_back(item);
  endfunction

  function automatic void push_segment(input logic [63:0] disk, input logic [63:0] len,
                                       input logic status, input logic last);
    rsp_t seg;
    seg.disk_addr = disk[DISK_W-1:0];
    seg.segment_length = len[SIZE_W-1:0];
    seg.status = status;
    seg.last = last;
    segment_q.push_back(seg);
  endfunction

  function automatic void predict_segments(input req_t item);
    logic [63:0] loc;
    logic [63:0] remaining;
    logic [63:0] start;
    logic [63:0] ext_stop;
    logic [63:0] off;
    logic [63:0] avail;
    logic [63:0] take;
    int          used;
    int          i;
    if (item.opcode == OP_LOAD) begin
      sector_tab[item.extent_index] = item.extent_lba;
      length_tab[item.extent_index] = item.ext_bytes;
      return;
    end
    loc = 64'(item.file_offset);
    remaining = 64'(item.byte_count);
    if (remaining == 0) begin
      push_segment('0, '0, ST_OK, 1'b1);
      return;
    end
    used = (ext_count_cfg > MAX_EXTENTS) ? MAX_EXTENTS : int'(ext_count_cfg);
    start = '0;
    for (i = 0; i < used && remaining != 0; i++) begin
      ext_stop = start + 64'(length_tab[i]);
      if (loc < ext_stop) begin
        off = (loc > start) ? loc - start : 64'd0;
        avail = 64'(length_tab[i]) - off;
        take = (remaining < avail) ? remaining : avail;
        loc = loc + take;
        remaining = remaining - take;
        push_segment((64'(sector_tab[i]) << SECTOR_SHIFT) + off, take, ST_OK, remaining == 0);
      end
      start = ext_stop;
    end
    if (remaining != 0) begin
      push_segment('0, '0, ST_PAST_EOF, 1'b1);
    end
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  task automatic wait_drained();
    while (pending_items.size() != 0 || req_ch.valid || segment_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin : drive_req
    bit   hold;
    req_t next_item;
    if (rst) begin
      req_ch.valid <= 1'b0;
      req_ch.data <= '0;
      req_gap = 0;
    end else begin
      hold = req_ch.valid;
      if (req_ch.valid && req_ch.ready) begin
        predict_segments(req_ch.data);
        hold = 1'b0;
        req_gap = idle_on ? $urandom_range(0, 6) : 0;
      end
      if (!hold) begin
        if (req_gap > 0) begin
          req_gap--;
        end else if (pending_items.size() != 0) begin
          next_item = pending_items.pop_front();
          req_ch.data <= next_item;
          hold = 1'b1;
        end
      end
      req_ch.valid <= hold;
    end
  end

  always @(posedge clk) begin : check_rsp
    rsp_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      rsp_stall = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (segment_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result item, expected none, actual %h", $time, rsp_ch.data);
        end else begin
          want = segment_q.pop_front();
          check_field("disk_addr", 64'(want.disk_addr), 64'(rsp_ch.data.disk_addr));
          check_field("segment_length", 64'(want.segment_length),
                      64'(rsp_ch.data.segment_length));
          check_field("status", 64'(want.status), 64'(rsp_ch.data.status));
          check_field("last", 64'(want.last), 64'(rsp_ch.data.last));
        end
        rsp_stall = idle_on ? $urandom_range(0, 6) : 0;
      end
      if (rsp_stall > 0) begin
        rsp_stall--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int          p;
    int          n;
    int          e;
    int          k;
    int          pick;
    logic [63:0] total;
    logic [63:0] base;
    logic [63:0] off;
    logic [63:0] rest;
    logic [63:0] cnt;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (p = 0; p < NUM_PHASES; p++) begin
      idle_on = ($urandom_range(0, 3) != 0);
      cfg_ch.valid <= 1'b1;
      cfg_ch.data <= PHASE_COUNTS[p];
      do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
      cfg_ch.valid <= 1'b0;
      ext_count_cfg = PHASE_COUNTS[p];
      plan_used = (PHASE_COUNTS[p] > MAX_EXTENTS) ? MAX_EXTENTS : int'(PHASE_COUNTS[p]);
      for (e = 0; e < plan_used; e++) begin
        if (!plan_written[e]) queue_load(IDX_W'(e), $urandom, rand_len());
      end

      if (p == 0) begin
        // A zero-length extent, the largest extent at the last sector, then two small ones.
        queue_load(5'd0, '0, '0);
        queue_load(5'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_load(5'd2, 32'd12345, 32'd100);
        queue_load(5'd3, 32'd7, 32'd1);
        queue_map('0, '0);
        queue_map('1, '0);
        queue_map('0, 48'd1);
        queue_map(48'hFFFF_FFFE, 48'd1);
        queue_map(48'hFFFF_FFFE, 48'd3);
        queue_map('0, 48'h1_0000_0064);
        queue_map('0, '1);
        queue_map(48'h1_0000_0064, 48'd1);
        queue_map('1, '1);
        queue_map(48'h1_0000_0063, 48'd1);
        queue_load(5'd31, 32'h5555_5555, 32'hAAAA_AAAA);
      end

      for (n = 0; n < RANDOM_PER_PHASE; n++) begin
        total = '0;
        for (e = 0; e < plan_used; e++) total += 64'(plan_len[e]);
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
          queue_load(IDX_W'($urandom_range(0, MAX_EXTENTS - 1)), $urandom, rand_len());
        end else if (pick < 16) begin
          queue_map(rand_pos(), '0);
        end else if (pick < 22 || total == 0) begin
          cnt = rand64() >> $urandom_range(16, 63);
          queue_map($urandom_range(0, 1) ? rand_pos() : '0, (cnt == 0) ? 48'd1 : cnt[POS_W-1:0]);
        end else begin
          e = $urandom_range(0, plan_used - 1);
          base = '0;
          for (k = 0; k < e; k++) base += 64'(plan_len[k]);
          case ($urandom_range(0, 3))
            0: off = base;
            1: off = base + ((plan_len[e] == 0) ? 64'd0 : rand64() % 64'(plan_len[e]));
            2: off = rand64() % total;
            default: off = (total > 16) ? total - $urandom_range(1, 16) : 64'd0;
          endcase
          rest = total - off;
          case ($urandom_range(0, 4))
            0: cnt = $urandom_range(1, 64);
            1: cnt = (rest == 0) ? 64'd1 : 64'd1 + rand64() % rest;
            2: cnt = (rest == 0) ? 64'd1 : rest;
            3: cnt = rest + $urandom_range(1, 4096);
            default: cnt = 64'd1 + rand64() % 64'h1_0000_0000;
          endcase
          queue_map(off[POS_W-1:0], cnt[POS_W-1:0]);
        end
      end
      wait_drained();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (segment_q.size() != 0) begin
      errors++;
      $display("%0t: result items missing, expected %0d more, actual 0", $time,
               segment_q.size());
    end
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
